@@ rtl/wbe_pkg.sv @@
package wbe_pkg;

   localparam int BYTES_W  = 16;
   localparam int TIME_W   = 64;
   localparam int RATE_W   = 37;
   localparam int SUM_W    = 40;
   localparam int SCALED_W = 40;
   localparam int WIN_W    = 32;
   localparam int STALL_W  = 8;
   localparam int LIMIT_W  = WIN_W + STALL_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = RATE_W;
   localparam int STATUS_W = 2;

   // 8 * 1e6 = 15625 << 9
   localparam int MUL_K_W  = 14;
   localparam logic [MUL_K_W-1:0] MUL_K = 14'd15625;
   localparam int MUL_SHIFT = 9;
   localparam int PROD_W   = SUM_W + MUL_K_W;

   localparam int DIV_W    = 64;
   localparam int DIV_CNT_W = 6;

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
   localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
   localparam logic [WIN_W-1:0]  WIN_RESET = 32'd100000;
   localparam logic [STALL_W-1:0] STALL_RESET = 8'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL  = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_ACCUM    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_ANCHORED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_UPDATED  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_OUTAGE   = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EVAL   = 7'b0000010,
      ST_MULT   = 7'b0000100,
      ST_LAUNCH = 7'b0001000,
      ST_DIVIDE = 7'b0010000,
      ST_BLEND  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIV_W-1:0]  divisor;
   } div_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIV_W-1:0]  quotient;
   } div_stat_type;

endpackage

@@ rtl/wbe_ifs.sv @@
interface wbe_req_if;
   logic                         valid;
   logic                         ready;
   logic [wbe_pkg::BYTES_W-1:0]  packet_bytes;
   logic [wbe_pkg::TIME_W-1:0]   time_us;

   modport source (output valid, output packet_bytes, output time_us, input ready);
   modport sink   (input valid, input packet_bytes, input time_us, output ready);
endinterface

interface wbe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [wbe_pkg::RATE_W-1:0]    bitrate;
   logic [wbe_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output bitrate, output status, input ready);
   modport sink   (input valid, input bitrate, input status, output ready);
endinterface

@@ rtl/windowed_bitrate_estimator.sv @@
// Packet bitrate meter: each req item carries a byte count and a microsecond
// timestamp, and each one gives exactly one rsp item with the smoothed rate
// in bits per second and a status (accumulating, window anchored, rate
// updated, outage with rate kept). The rate is a running average with weight
// 1/8 held at eight times scale. The block takes one packet at a time and
// accepts the next only once the last one's result is placed on rsp: a
// packet that anchors, accumulates or hits an outage passes the evaluate and
// finish steps; a packet that closes a window and takes a sample also passes
// the multiply, launch, divide and blend steps, the 64-step radix-2 divider
// computing bytes * 8e6 / elapsed. A result held on rsp
// stalls the next one until it is taken. Register 0 (seed rate) restarts the
// estimator; registers 1 and 2 set the window length and the outage multiple.
// Write registers only while no packet is in progress.
module windowed_bitrate_estimator (
   input  logic                              clock,
   input  logic                              reset,
   wbe_req_if.sink                           req_chan,
   wbe_rsp_if.source                         rsp_chan,
   input  logic                              csr_we,
   input  logic [wbe_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wbe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import wbe_pkg::*;

   state_type state_ff, state_in;

   logic [WIN_W-1:0]    win_ff, win_in;
   logic [STALL_W-1:0]  stall_ff, stall_in;

   logic                anchored_ff, anchored_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;
   logic [RATE_W-1:0]   current_ff, current_in;

   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [SUM_W-1:0]    close_sum_ff, close_sum_in;
   logic [TIME_W-1:0]   dt_ff, dt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0]   rsp_rate_ff, rsp_rate_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [WIN_W-1:0]    win_eff;
   logic [LIMIT_W-1:0]  limit;
   logic [TIME_W-1:0]   dt;
   logic [SUM_W:0]      sum_wide;
   logic [SUM_W-1:0]    sum_sat;
   logic [RATE_W-1:0]   sample;
   logic [SCALED_W-1:0] blended;
   logic                out_free;

   div_ctl_type  div_ctl;
   div_stat_type div_stat;

   wbe_divider u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   assign win_eff  = (win_ff == '0) ? {{(WIN_W-1){1'b0}}, 1'b1} : win_ff;
   assign limit    = win_eff * stall_ff;
   assign dt       = now_ff - start_ff;
   assign sum_wide = {1'b0, sum_ff} + {{(SUM_W+1-BYTES_W){1'b0}}, bytes_ff};
   assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

   assign sample = (div_stat.quotient > {{(DIV_W-RATE_W){1'b0}}, RATE_MAX})
                   ? RATE_MAX : div_stat.quotient[RATE_W-1:0];
   assign blended = (scaled_ff == '0) ? {sample, 3'b000}
                    : scaled_ff - {3'b000, scaled_ff[SCALED_W-1:3]}
                      + {{(SCALED_W-RATE_W){1'b0}}, sample};

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign div_ctl.start    = (state_ff == ST_LAUNCH);
   assign div_ctl.dividend = {{(DIV_W-PROD_W-MUL_SHIFT){1'b0}}, prod_ff,
                              {MUL_SHIFT{1'b0}}};
   assign div_ctl.divisor  = dt_ff;

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.bitrate  = rsp_rate_ff;
   assign rsp_chan.status   = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      win_in        = win_ff;
      stall_in      = stall_ff;
      anchored_in   = anchored_ff;
      start_in      = start_ff;
      sum_in        = sum_ff;
      scaled_in     = scaled_ff;
      current_in    = current_ff;
      bytes_in      = bytes_ff;
      now_in        = now_ff;
      close_sum_in  = close_sum_ff;
      dt_in         = dt_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_rate_in   = rsp_rate_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               bytes_in = req_chan.packet_bytes;
               now_in   = req_chan.time_us;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = ST_FINISH;
            if (!anchored_ff) begin
               anchored_in = 1'b1;
               start_in    = now_ff;
               sum_in      = '0;
               status_in   = STAT_ANCHORED;
            end else if (dt < {{(TIME_W-WIN_W){1'b0}}, win_eff}) begin
               sum_in    = sum_sat;
               status_in = STAT_ACCUM;
            end else begin
               start_in = now_ff;
               sum_in   = '0;
               if (dt <= {{(TIME_W-LIMIT_W){1'b0}}, limit}) begin
                  close_sum_in = sum_sat;
                  dt_in        = dt;
                  state_in     = ST_MULT;
               end else begin
                  status_in = STAT_OUTAGE;
               end
            end
         end
         ST_MULT: begin
            prod_in  = close_sum_ff * MUL_K;
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            scaled_in  = blended;
            current_in = blended[SCALED_W-1:3];
            status_in  = STAT_UPDATED;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rate_in   = current_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a seed write restarts the estimator
      if (csr_we) begin
         case (csr_index)
            CSR_SEED: begin
               anchored_in = 1'b0;
               start_in    = '0;
               sum_in      = '0;
               scaled_in   = {csr_wdata, 3'b000};
               current_in  = csr_wdata;
            end
            CSR_WINDOW: win_in   = csr_wdata[WIN_W-1:0];
            CSR_STALL:  stall_in = csr_wdata[STALL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff      <= bytes_in;
      now_ff        <= now_in;
      close_sum_ff  <= close_sum_in;
      dt_ff         <= dt_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= WIN_RESET;
         stall_ff     <= STALL_RESET;
         anchored_ff  <= 1'b0;
         start_ff     <= '0;
         sum_ff       <= '0;
         scaled_ff    <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         stall_ff     <= stall_in;
         anchored_ff  <= anchored_in;
         start_ff     <= start_in;
         sum_ff       <= sum_in;
         scaled_ff    <= scaled_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

   a_seed_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == CSR_SEED) |=>
         !anchored_ff && sum_ff == '0 && current_ff == $past(csr_wdata)
         && scaled_ff == {$past(csr_wdata), 3'b000})
      else $error("seed write did not restart the estimator");

   a_blend_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLEND && !csr_we) |=>
         current_ff == scaled_ff[SCALED_W-1:3] && status_ff == STAT_UPDATED)
      else $error("rate and scaled average disagree after a sample");

   a_launch_runs: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LAUNCH |=> state_ff == ST_DIVIDE && div_stat.busy)
      else $error("division not running after launch");

endmodule

@@ rtl/wbe_divider.sv @@
module wbe_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  wbe_pkg::div_ctl_type  ctl,
   output wbe_pkg::div_stat_type stat
);
   import wbe_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       diff;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = '0;
         quo_in  = ctl.dividend;
         dvs_in  = ctl.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIV_W]) begin
            rem_in = diff[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == {DIV_CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("divider done without a running division");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff && cnt_ff == '0)
      else $error("divider start did not begin a division");

   a_done_one_cycle: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule
